[design/prt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants for the point record table
// Request codes, status codes and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);

    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_DEL_NAME = 3'd1;
    localparam logic [2:0] REQ_DEL_XY   = 3'd2;
    localparam logic [2:0] REQ_FND_NAME = 3'd3;
    localparam logic [2:0] REQ_FND_XY   = 3'd4;
    localparam logic [2:0] REQ_RANGE    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic             load_req;
        logic             clr_idx;
        logic             inc_idx;
        logic             do_insert;
        logic             do_remove;
        logic             rewind_idx;
        logic             load_out;
        logic [1:0]       out_status;
        logic             out_rec;
        logic             out_last;
    } prt_cmd_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             full;
        logic             scan_done;
        logic             hit;
        logic             pend_valid;
        logic             any_hit;
        logic             out_busy;
    } prt_stat_t;

endpackage

[design/point_record_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_record_table: bounded table of named points, newest first
//
//   channel | dir | tdata (low bit up)                          | tuser
//   s_axis  | in  | req_type, key_name, coord_x, coord_y, radius| -
//   m_axis  | out | status, rec_name, rec_x, rec_y              | - (tlast=last)
//
// Insert and invalid requests are answered from the decode state; other requests
// scan one slot per cycle while m_axis is not stalled, through the single-slot
// compare and square pipeline. aresetn clears the table count and valid bits.
// A range hit is held until the next hit or the scan end fixes tlast.
// A stalled m_axis rewinds the scan to the pending slot; s_axis is taken once
// the request finishes.
// ----------------------------------------------------------------------------
module point_record_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,   // req_type, key_name, coord_x, coord_y, radius
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // status, rec_name, rec_x, rec_y
    output logic         m_axis_tlast
);

    prt_pkg::prt_cmd_t  cmd;
    prt_pkg::prt_stat_t stat;
    logic [1:0]         st;
    logic [63:0]        nm;
    logic signed [15:0] rx, ry;

    prt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .req_type (s_axis_tdata[2:0]),
        .key_name (s_axis_tdata[66:3]),
        .coord_x  (s_axis_tdata[82:67]),
        .coord_y  (s_axis_tdata[98:83]),
        .radius   (s_axis_tdata[114:99]),
        .o_status (st),
        .o_name   (nm),
        .o_x      (rx),
        .o_y      (ry),
        .o_last   (m_axis_tlast),
        .o_valid  (m_axis_tvalid),
        .o_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, ry, rx, nm, st};

endmodule

[design/prt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_datapath: table storage, scan pointer, match and distance pipeline
// Holds the packed entries, compares one slot per cycle unless a stalled output
// rewinds the scan, and drives the result register.
// ----------------------------------------------------------------------------
module prt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  prt_pkg::prt_cmd_t   cmd,
    output prt_pkg::prt_stat_t  stat,
    input  logic [2:0]          req_type,
    input  logic [63:0]         key_name,
    input  logic signed [15:0]  coord_x,
    input  logic signed [15:0]  coord_y,
    input  logic [15:0]         radius,
    output logic [1:0]          o_status,
    output logic [63:0]         o_name,
    output logic signed [15:0]  o_x,
    output logic signed [15:0]  o_y,
    output logic                o_last,
    output logic                o_valid,
    input  logic                o_ready
);

    localparam int D = prt_pkg::TableDepth;
    localparam int IW = prt_pkg::IdxW;
    localparam int CW = prt_pkg::CntW;

    logic [63:0]        name_reg [D];
    logic signed [15:0] x_reg    [D];
    logic signed [15:0] y_reg    [D];
    logic [D-1:0]       valid_reg;
    logic [CW-1:0]      count_reg;

    logic [2:0]         rq_type_reg;
    logic [63:0]        rq_name_reg;
    logic signed [15:0] rq_x_reg, rq_y_reg;
    logic [31:0]        r2_reg;
    logic [CW-1:0]      idx_reg, idx_next;

    // one-stage pipeline: squares registered, then compared
    logic               pend_reg;
    logic [IW-1:0]      pidx_reg;
    logic [33:0]        dx2_reg, dy2_reg;
    logic               peq_reg;
    // held hit: first match, or newest range hit not yet sent
    logic               hit_reg;
    logic [IW-1:0]      hidx_reg;

    logic [1:0]         ost_reg;
    logic [63:0]        oname_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic               olast_reg, ovalid_reg;

    logic [IW-1:0]      cur;
    logic signed [16:0] dx, dy;
    logic               eq_now, pmatch, by_name, is_range;

    assign cur      = idx_reg[IW-1:0];
    assign by_name  = (rq_type_reg == prt_pkg::REQ_DEL_NAME) ||
                      (rq_type_reg == prt_pkg::REQ_FND_NAME);
    assign is_range = (rq_type_reg == prt_pkg::REQ_RANGE);
    assign dx       = 17'(rq_x_reg) - 17'(x_reg[cur]);
    assign dy       = 17'(rq_y_reg) - 17'(y_reg[cur]);
    assign eq_now   = by_name ? (name_reg[cur] == rq_name_reg)
                              : (x_reg[cur] == rq_x_reg && y_reg[cur] == rq_y_reg);
    assign pmatch   = is_range ? ((35'(dx2_reg) + 35'(dy2_reg)) <= 35'(r2_reg))
                               : peq_reg;
    assign idx_next = cmd.clr_idx    ? '0 :
                      cmd.rewind_idx ? CW'(pidx_reg) :
                      (cmd.inc_idx ? idx_reg + 1'b1 : idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            idx_reg  <= idx_next;
            pend_reg <= cmd.inc_idx;
            if (cmd.clr_idx) begin
                hit_reg  <= 1'b0;
            end else if (pend_reg && pmatch && !hit_reg) begin
                hit_reg  <= 1'b1;
                hidx_reg <= pidx_reg;
            end else if (pend_reg && pmatch && cmd.load_out) begin
                hidx_reg <= pidx_reg;
            end
            if (cmd.do_insert) begin
                valid_reg[count_reg[IW-1:0]] <= 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.do_remove) begin
                valid_reg[IW'(count_reg - 1'b1)] <= 1'b0;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.load_out)
                ovalid_reg <= 1'b1;
            else if (o_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            rq_type_reg <= req_type;
            rq_name_reg <= key_name;
            rq_x_reg    <= coord_x;
            rq_y_reg    <= coord_y;
            r2_reg      <= radius * radius;
        end
        pidx_reg <= cur;
        dx2_reg  <= 34'(dx * dx);
        dy2_reg  <= 34'(dy * dy);
        peq_reg  <= eq_now;
        if (cmd.do_insert) begin
            for (int i = D - 1; i > 0; i--) begin
                name_reg[i] <= name_reg[i-1];
                x_reg[i]    <= x_reg[i-1];
                y_reg[i]    <= y_reg[i-1];
            end
            name_reg[0] <= rq_name_reg;
            x_reg[0]    <= rq_x_reg;
            y_reg[0]    <= rq_y_reg;
        end
        if (cmd.do_remove) begin
            for (int i = 0; i < D - 1; i++) begin
                if (IW'(i) >= hidx_reg) begin
                    name_reg[i] <= name_reg[i+1];
                    x_reg[i]    <= x_reg[i+1];
                    y_reg[i]    <= y_reg[i+1];
                end
            end
        end
        if (cmd.load_out) begin
            ost_reg   <= cmd.out_status;
            olast_reg <= cmd.out_last;
            if (cmd.out_rec) begin
                oname_reg <= cmd.do_insert ? rq_name_reg : name_reg[hidx_reg];
                ox_reg    <= cmd.do_insert ? rq_x_reg : x_reg[hidx_reg];
                oy_reg    <= cmd.do_insert ? rq_y_reg : y_reg[hidx_reg];
            end else begin
                oname_reg <= '0;
                ox_reg    <= '0;
                oy_reg    <= '0;
            end
        end
    end

    assign stat.req_type   = rq_type_reg;
    assign stat.full       = (count_reg == CW'(D));
    assign stat.scan_done  = (idx_reg >= count_reg);
    assign stat.hit        = pmatch;
    assign stat.pend_valid = pend_reg;
    assign stat.any_hit    = hit_reg;
    assign stat.out_busy   = ovalid_reg && !o_ready;

    assign o_status = ost_reg;
    assign o_name   = oname_reg;
    assign o_x      = ox_reg;
    assign o_y      = oy_reg;
    assign o_last   = olast_reg;
    assign o_valid  = ovalid_reg;

    a_cnt_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("valid bits disagree with count");
    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_insert |-> count_reg < CW'(D)) else $error("insert into full table");
    a_no_remove_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_remove |-> count_reg != '0) else $error("remove from empty table");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(D)) else $error("count out of range");

endmodule

[design/prt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_ctrl: request sequencer for the point record table
// Decodes a request, runs the slot scan and issues result transactions.
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  prt_pkg::prt_stat_t  stat,
    output prt_pkg::prt_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       is_range, is_del, next_hit;

    assign is_range = (stat.req_type == prt_pkg::REQ_RANGE);
    assign is_del   = (stat.req_type == prt_pkg::REQ_DEL_NAME) ||
                      (stat.req_type == prt_pkg::REQ_DEL_XY);
    assign next_hit = stat.pend_valid && stat.hit && stat.any_hit;
    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load_req = 1'b1;
                    cmd.clr_idx  = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!stat.out_busy) begin
                    if (stat.req_type == prt_pkg::REQ_INSERT) begin
                        cmd.load_out = 1'b1;
                        cmd.out_last = 1'b1;
                        if (stat.full) begin
                            cmd.out_status = prt_pkg::ST_FULL;
                        end else begin
                            cmd.do_insert  = 1'b1;
                            cmd.out_status = prt_pkg::ST_OK;
                            cmd.out_rec    = 1'b1;
                        end
                        state_next = S_IDLE;
                    end else if (stat.req_type > prt_pkg::REQ_RANGE) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = prt_pkg::ST_INVALID;
                        state_next     = S_IDLE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (is_range) begin
                    // a new hit releases the held one; tlast is decided at scan end
                    if (next_hit && stat.out_busy) begin
                        // output stalled: rewind to the pending slot and replay it
                        cmd.rewind_idx = 1'b1;
                    end else begin
                        if (next_hit) begin
                            cmd.load_out   = 1'b1;
                            cmd.out_rec    = 1'b1;
                            cmd.out_status = prt_pkg::ST_OK;
                        end
                        if (stat.scan_done)
                            state_next = S_FINISH;
                        else
                            cmd.inc_idx = 1'b1;
                    end
                end else begin
                    if (stat.any_hit || (stat.pend_valid && stat.hit) || stat.scan_done)
                        state_next = S_FINISH;
                    else
                        cmd.inc_idx = 1'b1;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    if (stat.any_hit) begin
                        cmd.out_status = prt_pkg::ST_OK;
                        cmd.out_rec    = 1'b1;
                        cmd.do_remove  = is_del;
                    end else begin
                        cmd.out_status = prt_pkg::ST_MISS;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.do_insert && cmd.do_remove)) else $error("insert and remove together");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !stat.out_busy) else $error("result overwritten");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_req |=> state_reg == S_DECODE) else $error("bad accept");

endmodule
